>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMNL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PMNL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/pmnl_pkg.sv
// Types, constants and codes shared by the page map modules.
`default_nettype none

package pmnl_pkg;

   localparam int ENTRIES   = 256;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int SIZE_W    = 4;
   localparam int ADDR_BITS = 24;
   localparam int LEVEL_W   = 4;
   localparam int PHYS_W    = 16;
   localparam int SPACE_W   = 8;
   localparam int DIM_W     = 2;
   localparam int SHIFT_W   = 6;

   localparam logic [DIM_W-1:0] DIM_RESET = 2'd2;

   typedef enum logic [1:0] {
      FUNC_MAP     = 2'd0,
      FUNC_UNMAP   = 2'd1,
      FUNC_EXACT   = 2'd2,
      FUNC_NEAREST = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      RSP_OK          = 2'd0,
      RSP_NOT_PRESENT = 2'd1,
      RSP_ALREADY     = 2'd2,
      RSP_FULL        = 2'd3
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0]    log_size;
      logic [ADDR_BITS-1:0] addr;
      logic [LEVEL_W-1:0]   level;
      logic [PHYS_W-1:0]    phys;
      logic [SPACE_W-1:0]   space;
   } entry_type;

   typedef struct packed {
      logic exact;
      logic near;
   } match_type;

endpackage

`default_nettype wire

>>> hdl/pmnl_entry_ram.sv
// Entry memory with one read and one write port, plus per-entry valid flags.
`default_nettype none

module pmnl_entry_ram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [pmnl_pkg::IDX_W-1:0]      rd_addr,
   output pmnl_pkg::entry_type             rd_entry,
   output logic                            rd_valid,
   input  logic                            wr_en,
   input  logic [pmnl_pkg::IDX_W-1:0]      wr_addr,
   input  pmnl_pkg::entry_type             wr_entry,
   input  logic                            clr_en,
   input  logic [pmnl_pkg::IDX_W-1:0]      clr_addr
);

   pmnl_pkg::entry_type               mem [pmnl_pkg::ENTRIES];
   logic [pmnl_pkg::ENTRIES-1:0]      valid_ff;
   pmnl_pkg::entry_type               rd_entry_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

>>> hdl/pmnl_match.sv
// Compares one stored entry against the exact key and the nearest-size candidates.
`default_nettype none

module pmnl_match (
   input  pmnl_pkg::entry_type                 ent,
   input  logic                                ent_valid,
   input  logic [pmnl_pkg::SIZE_W-1:0]         key_size,
   input  logic [pmnl_pkg::ADDR_BITS-1:0]      key_addr,
   input  logic [pmnl_pkg::SIZE_W:0]           min_size,
   input  logic [pmnl_pkg::DIM_W-1:0]          dims,
   output pmnl_pkg::match_type                 hit
);

   logic [pmnl_pkg::SHIFT_W-1:0]   shift;
   logic [pmnl_pkg::ADDR_BITS-1:0] mask;
   logic [pmnl_pkg::ADDR_BITS-1:0] cand;

   // The candidate at a larger size has the low dims*size bits cleared.
   always_comb begin
      shift = pmnl_pkg::SHIFT_W'(dims) * pmnl_pkg::SHIFT_W'(ent.log_size);
      if (shift >= pmnl_pkg::SHIFT_W'(pmnl_pkg::ADDR_BITS)) begin
         mask = '0;
      end else begin
         mask = {pmnl_pkg::ADDR_BITS{1'b1}} << shift;
      end
      cand = (ent.log_size == key_size) ? key_addr : (key_addr & mask);
      hit.exact = ent_valid && (ent.log_size == key_size) && (ent.addr == key_addr);
      hit.near  = ent_valid && ({1'b0, ent.log_size} >= min_size) && (ent.addr == cand);
   end

endmodule

`default_nettype wire

>>> hdl/mip_page_map_nearest_lookup.sv
// Top level of the mip page map: command sequencer around the entry memory scan.
// An accepted word passes the scan and finish states, then rsp_valid is registered; no
// new word is taken before the result, but one can be taken in the result cycle. Each
// item sweeps all 256 entries once, one memory read per cycle, and compares each entry
// read with the key at its own size. Reset clears all valid flags at once, the mapped
// count, and sets dimensions to 2. The receiver cannot stall; a result shows one cycle.
`default_nettype none

module mip_page_map_nearest_lookup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic [pmnl_pkg::SIZE_W-1:0]         req_log_size,
   input  logic [pmnl_pkg::ADDR_BITS-1:0]      req_virt_address,
   input  logic [pmnl_pkg::LEVEL_W-1:0]        req_mip_level,
   input  logic [pmnl_pkg::PHYS_W-1:0]         req_phys_page,
   input  logic [pmnl_pkg::SPACE_W-1:0]        req_space_id,
   input  logic                                req_want_ancestor,
   input  logic                                csr_wr_en,
   input  logic [pmnl_pkg::DIM_W-1:0]          csr_wr_data,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [pmnl_pkg::LEVEL_W-1:0]        rsp_found_level,
   output logic [pmnl_pkg::PHYS_W-1:0]         rsp_found_phys,
   output logic [pmnl_pkg::SPACE_W-1:0]        rsp_found_space,
   output logic [pmnl_pkg::SIZE_W-1:0]         rsp_found_log_size
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [pmnl_pkg::DIM_W-1:0]         dims_ff, dims_in;
   pmnl_pkg::func_type                 op_ff, op_in;
   pmnl_pkg::entry_type                key_ff, key_in;
   logic                               want_ff, want_in;
   logic [pmnl_pkg::CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                               cmp_pend_ff, cmp_pend_in;
   logic [pmnl_pkg::IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                               hit_ff, hit_in;
   logic [pmnl_pkg::IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   pmnl_pkg::entry_type                hit_data_ff, hit_data_in;
   logic                               best_ff, best_in;
   pmnl_pkg::entry_type                best_data_ff, best_data_in;
   logic                               free_ff, free_in;
   logic [pmnl_pkg::IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [pmnl_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   pmnl_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic                               rsp_found_ff, rsp_found_in;
   pmnl_pkg::entry_type                rsp_data_ff, rsp_data_in;

   logic                               issue;
   logic [pmnl_pkg::SIZE_W:0]          min_size;
   pmnl_pkg::entry_type                rd_entry;
   logic                               rd_valid;
   logic                               wr_en;
   logic                               clr_en;
   pmnl_pkg::match_type                match;

   assign issue    = (state_ff == ST_SCAN) &&
                     (rd_idx_ff != pmnl_pkg::CNT_W'(pmnl_pkg::ENTRIES));
   // Ancestor search after unmap starts one size above the removed page.
   assign min_size = (op_ff == pmnl_pkg::FUNC_UNMAP) ?
                     ({1'b0, key_ff.log_size} + 5'd1) : {1'b0, key_ff.log_size};

   pmnl_entry_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue),
      .rd_addr  (rd_idx_ff[pmnl_pkg::IDX_W-1:0]),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (free_idx_ff),
      .wr_entry (key_ff),
      .clr_en   (clr_en),
      .clr_addr (hit_idx_ff)
   );

   pmnl_match u_match (
      .ent       (rd_entry),
      .ent_valid (rd_valid),
      .key_size  (key_ff.log_size),
      .key_addr  (key_ff.addr),
      .min_size  (min_size),
      .dims      (dims_ff),
      .hit       (match)
   );

   always_comb begin
      state_in      = state_ff;
      dims_in       = csr_wr_en ? csr_wr_data : dims_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      want_in       = want_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_pend_in   = issue;
      cmp_idx_in    = rd_idx_ff[pmnl_pkg::IDX_W-1:0];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      best_in       = best_ff;
      best_data_in  = best_data_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      clr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in           = pmnl_pkg::func_type'(req_func);
               key_in.log_size = req_log_size;
               key_in.addr     = req_virt_address;
               key_in.level    = req_mip_level;
               key_in.phys     = req_phys_page;
               key_in.space    = req_space_id;
               want_in         = req_want_ancestor;
               rd_idx_in       = '0;
               hit_in          = 1'b0;
               best_in         = 1'b0;
               free_in         = 1'b0;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + pmnl_pkg::CNT_W'(1);
            end
            if (cmp_pend_ff) begin
               if (match.exact) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = cmp_idx_ff;
                  hit_data_in = rd_entry;
               end
               // Keep the smallest matching size.
               if (match.near && (!best_ff || (rd_entry.log_size < best_data_ff.log_size))) begin
                  best_in      = 1'b1;
                  best_data_in = rd_entry;
               end
               if (!rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
            end
            if (!issue && !cmp_pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = pmnl_pkg::RSP_OK;
            rsp_found_in  = 1'b0;
            rsp_data_in   = '0;
            unique case (op_ff)
               pmnl_pkg::FUNC_MAP: begin
                  if (hit_ff) begin
                     rsp_status_in = pmnl_pkg::RSP_ALREADY;
                     rsp_found_in  = 1'b1;
                     rsp_data_in   = hit_data_ff;
                  end else if (count_ff == pmnl_pkg::CNT_W'(pmnl_pkg::ENTRIES)) begin
                     rsp_status_in = pmnl_pkg::RSP_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + pmnl_pkg::CNT_W'(1);
                  end
               end
               pmnl_pkg::FUNC_UNMAP: begin
                  if (!hit_ff) begin
                     rsp_status_in = pmnl_pkg::RSP_NOT_PRESENT;
                  end else begin
                     clr_en   = 1'b1;
                     count_in = count_ff - pmnl_pkg::CNT_W'(1);
                     if (want_ff && best_ff) begin
                        rsp_found_in = 1'b1;
                        rsp_data_in  = best_data_ff;
                     end
                  end
               end
               pmnl_pkg::FUNC_EXACT: begin
                  if (hit_ff) begin
                     rsp_found_in = 1'b1;
                     rsp_data_in  = hit_data_ff;
                  end else begin
                     rsp_status_in = pmnl_pkg::RSP_NOT_PRESENT;
                  end
               end
               pmnl_pkg::FUNC_NEAREST: begin
                  if (best_ff) begin
                     rsp_found_in = 1'b1;
                     rsp_data_in  = best_data_ff;
                  end else begin
                     rsp_status_in = pmnl_pkg::RSP_NOT_PRESENT;
                  end
               end
               default: begin
                  rsp_status_in = pmnl_pkg::RSP_NOT_PRESENT;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= pmnl_pkg::DIM_RESET;
         count_ff     <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         best_ff      <= 1'b0;
         free_ff      <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         dims_ff      <= dims_in;
         count_ff     <= count_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         best_ff      <= best_in;
         free_ff      <= free_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      want_ff       <= want_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      best_data_ff  <= best_data_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_level    = rsp_data_ff.level;
   assign rsp_found_phys     = rsp_data_ff.phys;
   assign rsp_found_space    = rsp_data_ff.space;
   assign rsp_found_log_size = rsp_data_ff.log_size;

endmodule

`default_nettype wire

>>> hdl/pmnl_checker.sv
// Port-level checks for the mip page map, attached to the top level by bind.
`default_nettype none
`include "assert_macros.svh"

module pmnl_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_found,
   input  logic [3:0]  rsp_found_level,
   input  logic [15:0] rsp_found_phys,
   input  logic [7:0]  rsp_found_space,
   input  logic [3:0]  rsp_found_log_size
);

   logic data_zero;
   logic status_fail;

   assign data_zero   = (rsp_found_level == 4'd0) && (rsp_found_phys == 16'd0) &&
                        (rsp_found_space == 8'd0) && (rsp_found_log_size == 4'd0);
   assign status_fail = (rsp_status == pmnl_pkg::RSP_FULL) ||
                        (rsp_status == pmnl_pkg::RSP_NOT_PRESENT);

   // An accepted word keeps the block busy until its result.
   `PMNL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // Each result word ends the work of one item.
   `PMNL_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy) && !busy)
   `PMNL_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_found, data_zero)
   `PMNL_ASSERT_SAME(a_dup_found, rsp_valid && (rsp_status == pmnl_pkg::RSP_ALREADY), rsp_found)
   `PMNL_ASSERT_SAME(a_fail_nofound, rsp_valid && status_fail, !rsp_found)

endmodule

bind mip_page_map_nearest_lookup pmnl_checker u_pmnl_checker (.*);

`default_nettype wire

>>> bench/mip_page_map_nearest_lookup_tb.sv
// Self-checking bench for the mip page map with exact and nearest-size lookup.
`default_nettype none

module mip_page_map_nearest_lookup_tb;
   import pmnl_pkg::*;

   localparam int SIZE_LEVELS  = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      func_type                func;
      logic [SIZE_W-1:0]       size;
      logic [ADDR_BITS-1:0]    addr;
      logic [LEVEL_W-1:0]      level;
      logic [PHYS_W-1:0]       phys;
      logic [SPACE_W-1:0]      space;
      logic                    want;
   } page_op_t;

   typedef struct packed {
      status_type              status;
      logic                    found;
      logic [LEVEL_W-1:0]      level;
      logic [PHYS_W-1:0]       phys;
      logic [SPACE_W-1:0]      space;
      logic [SIZE_W-1:0]       log_size;
   } page_reply_t;

   typedef struct {
      logic [SIZE_W-1:0]       size;
      logic [ADDR_BITS-1:0]    addr;
   } page_key_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_func = '0;
   logic [SIZE_W-1:0]       req_log_size = '0;
   logic [ADDR_BITS-1:0]    req_virt_address = '0;
   logic [LEVEL_W-1:0]      req_mip_level = '0;
   logic [PHYS_W-1:0]       req_phys_page = '0;
   logic [SPACE_W-1:0]      req_space_id = '0;
   logic                    req_want_ancestor = 1'b0;
   logic                    csr_wr_en = 1'b0;
   logic [DIM_W-1:0]        csr_wr_data = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic                    rsp_found;
   logic [LEVEL_W-1:0]      rsp_found_level;
   logic [PHYS_W-1:0]       rsp_found_phys;
   logic [SPACE_W-1:0]      rsp_found_space;
   logic [SIZE_W-1:0]       rsp_found_log_size;

   // shadow copy of the page table
   bit                      slot_valid [ENTRIES];
   entry_type               slot_data [ENTRIES];
   int                      map_count = 0;
   logic [DIM_W-1:0]        dims_model = DIM_RESET;

   page_op_t                pending_ops [$];
   page_reply_t             expected_replies [$];
   page_key_t               map_keys [$];
   page_op_t                cur_op;

   int                      words_issued = 0;
   int                      words_resolved = 0;
   int                      mismatches = 0;
   int                      func_seen [4] = '{0, 0, 0, 0};
   int                      full_seen = 0;
   int                      cycle_count = 0;
   int                      gap_left = 0;
   bit                      gap_any = 1'b0;
   bit                      idle_on = 1'b1;

   mip_page_map_nearest_lookup dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_log_size       (req_log_size),
      .req_virt_address   (req_virt_address),
      .req_mip_level      (req_mip_level),
      .req_phys_page      (req_phys_page),
      .req_space_id       (req_space_id),
      .req_want_ancestor  (req_want_ancestor),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_found_level    (rsp_found_level),
      .rsp_found_phys     (rsp_found_phys),
      .rsp_found_space    (rsp_found_space),
      .rsp_found_log_size (rsp_found_log_size)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Clear the low dims*size address bits; a shift past the width clears all.
   function automatic logic [ADDR_BITS-1:0] strip_low(logic [ADDR_BITS-1:0] a,
                                                      int unsigned size);
      int unsigned shift;
      shift = dims_model * size;
      if (shift >= ADDR_BITS)
         return '0;
      return a & ({ADDR_BITS{1'b1}} << shift);
   endfunction

   function automatic int find_slot(int unsigned size, logic [ADDR_BITS-1:0] a);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_data[i].log_size == size && slot_data[i].addr == a)
            return i;
      end
      return -1;
   endfunction

   function automatic int find_nearest(int unsigned size, logic [ADDR_BITS-1:0] a);
      int hit;
      while (size < SIZE_LEVELS) begin
         hit = find_slot(size, a);
         if (hit >= 0)
            return hit;
         size++;
         a = strip_low(a, size);
      end
      return -1;
   endfunction

   function automatic page_reply_t reply_from_slot(status_type st, int hit);
      page_reply_t r;
      r = '0;
      r.status = st;
      if (hit >= 0) begin
         r.found    = 1'b1;
         r.level    = slot_data[hit].level;
         r.phys     = slot_data[hit].phys;
         r.space    = slot_data[hit].space;
         r.log_size = slot_data[hit].log_size;
      end
      return r;
   endfunction

   // Work out the reply to one word and update the shadow table.
   function automatic page_reply_t predict_reply(page_op_t op);
      page_reply_t res;
      int          hit;
      int          slot;
      int unsigned up;
      hit = -1;
      up = int'(op.size) + 1;
      case (op.func)
         FUNC_MAP: begin
            hit = find_slot(op.size, op.addr);
            if (hit >= 0) begin
               res = reply_from_slot(RSP_ALREADY, hit);
            end else if (map_count >= ENTRIES) begin
               res = reply_from_slot(RSP_FULL, -1);
            end else begin
               res = reply_from_slot(RSP_OK, -1);
               slot = 0;
               while (slot_valid[slot])
                  slot++;
               slot_valid[slot] = 1'b1;
               slot_data[slot] = '{log_size: op.size, addr: op.addr, level: op.level,
                                   phys: op.phys, space: op.space};
               map_count++;
            end
         end
         FUNC_UNMAP: begin
            hit = find_slot(op.size, op.addr);
            if (hit < 0) begin
               res = reply_from_slot(RSP_NOT_PRESENT, -1);
            end else begin
               slot_valid[hit] = 1'b0;
               map_count--;
               if (op.want)
                  res = reply_from_slot(RSP_OK, find_nearest(up, strip_low(op.addr, up)));
               else
                  res = reply_from_slot(RSP_OK, -1);
            end
         end
         default: begin
            if (op.func == FUNC_EXACT)
               hit = find_slot(op.size, op.addr);
            else
               hit = find_nearest(op.size, op.addr);
            if (hit < 0)
               res = reply_from_slot(RSP_NOT_PRESENT, -1);
            else
               res = reply_from_slot(RSP_OK, hit);
         end
      endcase
      return res;
   endfunction

   // Driver: predict on acceptance, then present the next word or idle.
   always @(posedge clock) begin
      page_reply_t pred;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            pred = predict_reply(cur_op);
            expected_replies.push_back(pred);
            func_seen[cur_op.func]++;
            if (pred.status == RSP_FULL)
               full_seen++;
            if (idle_on && $urandom_range(0, 2) == 0) begin
               gap_left = $urandom_range(1, 19);
               gap_any = 1'($urandom_range(0, 1));
            end
         end
         if (start && busy) begin
            // hold the word until the block takes it
         end else if (gap_left > 0) begin
            if (gap_any || !busy)
               gap_left--;
            start <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            cur_op = pending_ops.pop_front();
            req_func          <= cur_op.func;
            req_log_size      <= cur_op.size;
            req_virt_address  <= cur_op.addr;
            req_mip_level     <= cur_op.level;
            req_phys_page     <= cur_op.phys;
            req_space_id      <= cur_op.space;
            req_want_ancestor <= cur_op.want;
            start             <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   // Monitor: every strobed word is taken at once.
   always @(posedge clock) begin
      page_reply_t want_r;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $error("result word with no expectation pending");
            mismatches++;
         end else begin
            want_r = expected_replies.pop_front();
            check_field("status", want_r.status, rsp_status);
            check_field("found", want_r.found, rsp_found);
            check_field("found_level", want_r.level, rsp_found_level);
            check_field("found_phys", want_r.phys, rsp_found_phys);
            check_field("found_space", want_r.space, rsp_found_space);
            check_field("found_log_size", want_r.log_size, rsp_found_log_size);
            words_resolved++;
         end
      end
   end

   task automatic queue_op(input page_op_t op);
      pending_ops.push_back(op);
      words_issued++;
   endtask

   function automatic page_op_t make_op(func_type f, int unsigned size,
                                        logic [ADDR_BITS-1:0] a, logic [LEVEL_W-1:0] lvl,
                                        logic [PHYS_W-1:0] ph, logic [SPACE_W-1:0] sp,
                                        logic want);
      page_op_t op;
      op.func  = f;
      op.size  = SIZE_W'(size);
      op.addr  = a;
      op.level = lvl;
      op.phys  = ph;
      op.space = sp;
      op.want  = want;
      return op;
   endfunction

   task automatic wait_idle();
      while (words_resolved != words_issued)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dims(input logic [DIM_W-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dims_model = v;
   endtask

   // Mostly key-aware traffic around a few base addresses, plus raw noise.
   task automatic add_random(input int count);
      page_op_t             op;
      page_key_t            k;
      logic [ADDR_BITS-1:0] bases [8];
      logic [ADDR_BITS-1:0] low_mask;
      int                   pick;
      foreach (bases[i])
         bases[i] = ADDR_BITS'($urandom);
      repeat (count) begin
         op.func  = func_type'($urandom_range(0, 3));
         op.size  = SIZE_W'($urandom_range(0, 15));
         op.addr  = ADDR_BITS'($urandom);
         op.level = LEVEL_W'($urandom);
         op.phys  = PHYS_W'($urandom);
         op.space = SPACE_W'($urandom);
         op.want  = 1'($urandom);
         pick = $urandom_range(0, 99);
         if (pick >= 10) begin
            if ($urandom_range(0, 1))
               op.size = SIZE_W'($urandom_range(0, 5));
            op.addr = bases[$urandom_range(0, 7)] ^ ADDR_BITS'($urandom_range(0, 255));
            if (pick < 45) begin
               op.func = FUNC_MAP;
               op.addr = strip_low(op.addr, op.size);
               map_keys.push_back('{op.size, op.addr});
               if (map_keys.size() > 48)
                  void'(map_keys.pop_front());
            end else if (map_keys.size() == 0) begin
               op.func = FUNC_EXACT;
            end else begin
               k = map_keys[$urandom_range(0, map_keys.size() - 1)];
               op.size = k.size;
               op.addr = k.addr;
               if (pick < 62) begin
                  op.func = FUNC_UNMAP;
               end else if (pick < 77) begin
                  op.func = FUNC_EXACT;
               end else begin
                  // start below the mapped size with junk in the bits that get cleared
                  op.func = FUNC_NEAREST;
                  low_mask = ~strip_low('1, k.size);
                  op.size = SIZE_W'($urandom_range(0, k.size));
                  op.addr = k.addr ^ (ADDR_BITS'($urandom) & low_mask);
               end
            end
         end
         queue_op(op);
      end
   endtask

   // Map fresh keys until the table is full, then work at the full boundary.
   task automatic fill_table();
      page_key_t fill_keys [$];
      page_op_t  op;
      int        serial;
      serial = 1;
      while (map_count < ENTRIES) begin
         repeat (ENTRIES - map_count) begin
            op = make_op(FUNC_MAP, $urandom_range(0, 15),
                         ADDR_BITS'(serial * 32'h9e3779) ^ 24'h5a5a5a,
                         LEVEL_W'($urandom), PHYS_W'($urandom), SPACE_W'($urandom),
                         1'($urandom));
            fill_keys.push_back('{op.size, op.addr});
            queue_op(op);
            serial++;
         end
         wait_idle();
      end
      repeat (3) begin
         queue_op(make_op(FUNC_MAP, $urandom_range(0, 15),
                          ADDR_BITS'(serial * 32'h9e3779) ^ 24'h5a5a5a,
                          4'h3, 16'h0f0f, 8'h3c, 1'b0));
         serial++;
      end
      queue_op(make_op(FUNC_MAP, fill_keys[0].size, fill_keys[0].addr, 4'h0, 16'h0, 8'h0, 1'b0));
      queue_op(make_op(FUNC_EXACT, fill_keys[5].size, fill_keys[5].addr, 4'h0, 16'h0, 8'h0,
                       1'b0));
      queue_op(make_op(FUNC_NEAREST, fill_keys[7].size, fill_keys[7].addr, 4'h0, 16'h0, 8'h0,
                       1'b0));
      for (int i = 1; i <= 4; i++)
         queue_op(make_op(FUNC_UNMAP, fill_keys[i].size, fill_keys[i].addr, 4'h0, 16'h0, 8'h0,
                          1'($urandom)));
      repeat (2) begin
         queue_op(make_op(FUNC_MAP, $urandom_range(0, 15),
                          ADDR_BITS'(serial * 32'h9e3779) ^ 24'h5a5a5a,
                          4'hc, 16'h5555, 8'h81, 1'b0));
         serial++;
      end
      queue_op(make_op(FUNC_MAP, fill_keys[1].size, fill_keys[1].addr, 4'h9, 16'hbeef, 8'h42,
                       1'b0));
      queue_op(make_op(FUNC_EXACT, fill_keys[1].size, fill_keys[1].addr, 4'h0, 16'h0, 8'h0,
                       1'b0));
   endtask

   initial begin
      while (reset)
         @(posedge clock);

      // directed words, dimensions at reset value 2, table empty
      queue_op(make_op(FUNC_EXACT,    0, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST, 15, 24'hffffff, 4'hf, 16'hffff, 8'hff, 1'b1));
      queue_op(make_op(FUNC_UNMAP,    7, 24'h000080, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_MAP,      4, 24'h123400, 4'hf, 16'hffff, 8'hff, 1'b0));
      queue_op(make_op(FUNC_MAP,      4, 24'h123400, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_MAP,      0, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_MAP,     15, 24'h000000, 4'h7, 16'h1234, 8'h5a, 1'b0));
      queue_op(make_op(FUNC_EXACT,    4, 24'h123400, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST,  1, 24'h1234ff, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST, 14, 24'habcdef, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST, 15, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST,  0, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_UNMAP,    4, 24'h123400, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_UNMAP,    0, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_MAP,      3, 24'hfff000, 4'h1, 16'h8000, 8'h80, 1'b0));
      // ancestor search above the top size probes nothing
      queue_op(make_op(FUNC_UNMAP,   15, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_UNMAP,    3, 24'hfff000, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_UNMAP,    3, 24'hfff000, 4'h0, 16'h0000, 8'h00, 1'b1));
      queue_op(make_op(FUNC_EXACT,   15, 24'h000000, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_MAP,      8, 24'hffffff, 4'ha, 16'haaaa, 8'h55, 1'b0));
      queue_op(make_op(FUNC_EXACT,    8, 24'hffffff, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST,  8, 24'hffffff, 4'h0, 16'h0000, 8'h00, 1'b0));
      queue_op(make_op(FUNC_NEAREST,  7, 24'hffffff, 4'h0, 16'h0000, 8'h00, 1'b0));

      add_random(120);
      write_dims(2'd3);
      add_random(80);
      write_dims(2'd1);
      add_random(60);
      write_dims(2'd0);
      add_random(50);
      write_dims(2'd2);
      fill_table();
      write_dims(2'd3);
      idle_on = 1'b0;
      add_random(40);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d words: map %0d, unmap %0d, exact %0d, nearest %0d.",
               words_resolved, func_seen[FUNC_MAP], func_seen[FUNC_UNMAP],
               func_seen[FUNC_EXACT], func_seen[FUNC_NEAREST]);
      $display("Dimensions swept over 0 to 3; %0d map words hit a full table.", full_seen);
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/pmnl_pkg.sv
hdl/pmnl_entry_ram.sv
hdl/pmnl_match.sv
hdl/mip_page_map_nearest_lookup.sv
hdl/pmnl_checker.sv
bench/mip_page_map_nearest_lookup_tb.sv
